FILE: src/r2hsv_pkg.sv
// ----------------------------------------------------------------------------
// r2hsv_pkg
// Shared types and constants for the RGB to HSV pixel converter: pixel and
// result beats, the divider lane record and the cell record that walks the
// divider chain.
// ----------------------------------------------------------------------------
package r2hsv_pkg;

  // channel and result field widths
  localparam int CHAN_W = 8;
  localparam int HUE_W  = 9;
  localparam int PCT_W  = 7;

  // divider geometry: numerators fit in 17 bits, quotients in 9 bits
  localparam int NUM_W = 17;
  localparam int QUO_W = 9;

  // front register plus one cell per quotient bit
  localparam int LATENCY = QUO_W + 1;

  // scale factors
  localparam int SCALE_PCT = 100;
  localparam int FULL_SCALE = 255;
  localparam int DEG_SECTOR = 60;
  localparam int DEG_GREEN = 120;
  localparam int DEG_BLUE = 240;
  localparam int DEG_TURN = 360;

  // reciprocal of 255 scaled by 2^23, exact floor for numerators up to 100*255
  localparam int BRI_RECIP = 32897;
  localparam int BRI_SHIFT = 23;
  localparam int PROD_W    = 32;

  // input beat
  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  // output beat
  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [PCT_W-1:0] saturation;
    logic [PCT_W-1:0] brightness;
  } hsv_t;

  // one restoring-division lane: partial remainder, shifted divisor, quotient
  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [NUM_W-1:0] dsh;
    logic [QUO_W-1:0] quo;
  } div_lane_t;

  // record handed from cell to cell; brightness is settled in the front stage
  typedef struct packed {
    logic             valid;
    div_lane_t        hue;
    div_lane_t        sat;
    logic [PCT_W-1:0] bri;
  } cell_t;

endpackage

FILE: src/rgb_to_hsv_pixel_unit.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel_unit
// Converts one 8-bit RGB pixel per clock into hue (degrees), saturation and
// value (percent), using a front stage and a chain of divider cells.
// A beat passes from start to the valid strobe through one front register plus
// one cell per quotient bit of the 9-bit restoring divider chain.
// Throughput: one pixel every cycle; busy is never raised.
// Reset clears the valid flags along the chain; data registers are not reset.
// The result is shown for one cycle with valid and cannot be held off.
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  r2hsv_pkg::pixel_t pixel,
  output logic              valid,
  output r2hsv_pkg::hsv_t   result
);
  import r2hsv_pkg::*;

  cell_t chain [0:QUO_W];

  // the chain accepts a beat every cycle
  assign busy = 1'b0;

  // front stage
  r2hsv_prep u_prep (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .pixel (pixel),
    .dout  (chain[0])
  );

  // divider cells, one quotient bit each
  for (genvar i = 0; i < QUO_W; i++) begin : g_cell
    r2hsv_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (chain[i]),
      .dout (chain[i+1])
    );
  end

  // result beat from the last cell
  assign valid             = chain[QUO_W].valid;
  assign result.hue        = HUE_W'(chain[QUO_W].hue.quo);
  assign result.saturation = PCT_W'(chain[QUO_W].sat.quo);
  assign result.brightness = chain[QUO_W].bri;

  // every accepted beat comes out after the front register and every divider cell
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY valid)
    else $error("result beat missing at expected latency");

  // hue within one turn
  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    valid |-> (result.hue < HUE_W'(DEG_TURN)))
    else $error("hue out of range");

  // percentages within scale
  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    valid |-> (result.saturation <= PCT_W'(SCALE_PCT)) &&
              (result.brightness <= PCT_W'(SCALE_PCT)))
    else $error("percentage out of range");

  // a black pixel gives an all-zero result
  a_black: assert property (@(posedge clk) disable iff (rst)
    (start && (pixel == '0)) |-> ##LATENCY (valid && (result == '0)))
    else $error("black pixel not converted to zero");

endmodule

FILE: src/r2hsv_prep.sv
// ----------------------------------------------------------------------------
// r2hsv_prep
// Front stage: finds max, min and delta of the pixel, picks the hue sector,
// registers the numerator and divisor of the hue and saturation divisions
// and works out the brightness by reciprocal multiplication.
// ----------------------------------------------------------------------------
module r2hsv_prep (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  r2hsv_pkg::pixel_t pixel,
  output r2hsv_pkg::cell_t  dout
);
  import r2hsv_pkg::*;

  logic [CHAN_W-1:0] r, g, b;
  logic [CHAN_W-1:0] mx, mn, delta;
  logic [NUM_W-1:0]  hue_num, d17;
  logic [CHAN_W-1:0] hue_den, sat_den;
  logic [PROD_W-1:0] bri_prod;
  cell_t             cell_next;

  assign r = pixel.red;
  assign g = pixel.green;
  assign b = pixel.blue;

  // largest and smallest channel
  always_comb begin
    mx = (r > g) ? r : g;
    mn = (r > g) ? g : r;
    if (b > mx) begin
      mx = b;
    end
    if (b < mn) begin
      mn = b;
    end
    delta = mx - mn;
    d17 = NUM_W'(delta);
  end

  // hue numerator, sector of the largest channel, red then green then blue
  always_comb begin
    if (delta == '0) begin
      hue_num = '0;
    end else if (r == mx) begin
      if (g >= b) begin
        hue_num = NUM_W'(DEG_SECTOR) * NUM_W'(g - b);
      end else begin
        hue_num = NUM_W'(DEG_TURN) * d17 - NUM_W'(DEG_SECTOR) * NUM_W'(b - g);
      end
    end else if (g == mx) begin
      if (b >= r) begin
        hue_num = NUM_W'(DEG_GREEN) * d17 + NUM_W'(DEG_SECTOR) * NUM_W'(b - r);
      end else begin
        hue_num = NUM_W'(DEG_GREEN) * d17 - NUM_W'(DEG_SECTOR) * NUM_W'(r - b);
      end
    end else begin
      if (r >= g) begin
        hue_num = NUM_W'(DEG_BLUE) * d17 + NUM_W'(DEG_SECTOR) * NUM_W'(r - g);
      end else begin
        hue_num = NUM_W'(DEG_BLUE) * d17 - NUM_W'(DEG_SECTOR) * NUM_W'(g - r);
      end
    end
  end

  // a zero divisor only occurs with a zero numerator, so divide by one
  assign hue_den = (delta == '0) ? CHAN_W'(1) : delta;
  assign sat_den = (mx == '0) ? CHAN_W'(1) : mx;

  // brightness: max times 100 over 255 as one constant multiply and a shift
  assign bri_prod = PROD_W'(mx) * PROD_W'(SCALE_PCT * BRI_RECIP);

  // lane set-up: divisor aligned with the top quotient bit
  always_comb begin
    cell_next.valid   = start;
    cell_next.hue.rem = hue_num;
    cell_next.hue.dsh = NUM_W'(hue_den) << (QUO_W - 1);
    cell_next.hue.quo = '0;
    cell_next.sat.rem = NUM_W'(SCALE_PCT) * d17;
    cell_next.sat.dsh = NUM_W'(sat_den) << (QUO_W - 1);
    cell_next.sat.quo = '0;
    cell_next.bri     = bri_prod[BRI_SHIFT +: PCT_W];
  end

  // valid flag is reset, payload is not
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= cell_next.valid;
    end
    dout.hue <= cell_next.hue;
    dout.sat <= cell_next.sat;
    dout.bri <= cell_next.bri;
  end

endmodule

FILE: src/r2hsv_div_cell.sv
// ----------------------------------------------------------------------------
// r2hsv_div_cell
// One cell of the divider chain: settles one quotient bit in the hue and
// saturation lanes, carries the brightness along and hands the record on
// with the divisor halved.
// ----------------------------------------------------------------------------
module r2hsv_div_cell (
  input  logic             clk,
  input  logic             rst,
  input  r2hsv_pkg::cell_t din,
  output r2hsv_pkg::cell_t dout
);
  import r2hsv_pkg::*;

  cell_t cell_next;

  // restoring step: subtract where the shifted divisor fits
  function automatic div_lane_t lane_step(input div_lane_t l);
    div_lane_t o;
    logic      fits;
    fits  = (l.rem >= l.dsh);
    o.rem = fits ? (l.rem - l.dsh) : l.rem;
    o.dsh = l.dsh >> 1;
    o.quo = {l.quo[QUO_W-2:0], fits};
    return o;
  endfunction

  always_comb begin
    cell_next.valid = din.valid;
    cell_next.hue   = lane_step(din.hue);
    cell_next.sat   = lane_step(din.sat);
    cell_next.bri   = din.bri;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= cell_next.valid;
    end
    dout.hue <= cell_next.hue;
    dout.sat <= cell_next.sat;
    dout.bri <= cell_next.bri;
  end

  // remainder always ends below the divisor it was compared with
  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    din.valid |=> (dout.hue.rem < $past(din.hue.dsh)) &&
                  (dout.sat.rem < $past(din.sat.dsh)))
    else $error("divider remainder not reduced below divisor");

endmodule
